// File: rtl/srg_pkg.sv
package srg_pkg;

	localparam int unsigned VAL_W  = 30;
	localparam int unsigned SEED_W = 31;
	localparam int unsigned IDX_W  = 6;

	localparam int unsigned TAB_LEN = 55;

	localparam logic [VAL_W-1:0]  MOD_BIG     = 30'd1000000000;
	localparam logic [SEED_W-1:0] SEED_MIX    = 31'd161803398;
	localparam logic [IDX_W-1:0]  SCRAMBLE    = 6'd21;
	localparam logic [IDX_W-1:0]  TRAIL_START = 6'd31;
	localparam logic [IDX_W-1:0]  MIX_OFFSET  = 6'd30;
	localparam logic [IDX_W-1:0]  LAST_ADDR   = 6'(TAB_LEN - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEED_ABS,
		ST_SEED_MOD,
		ST_FILL,
		ST_MIX,
		ST_MIX_END,
		ST_PREP,
		ST_DRAW
	} state_t;

	typedef struct packed {
		logic             re;
		logic [IDX_W-1:0] raddr_a;
		logic [IDX_W-1:0] raddr_b;
		logic             we;
		logic [IDX_W-1:0] waddr;
		logic [VAL_W-1:0] wdata;
	} ram_ctl_t;

endpackage

// File: rtl/srg_in_if.sv
interface srg_in_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [30:0] seed;

	modport source (output valid, output req_type, output seed, input ready);
	modport sink (input valid, input req_type, input seed, output ready);
endinterface

// File: rtl/srg_out_if.sv
interface srg_out_if;
	logic        valid;
	logic        ready;
	logic [29:0] value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

// File: rtl/srg_alu.sv
module srg_alu (
	input  logic [srg_pkg::SEED_W-1:0] a,
	input  logic [srg_pkg::VAL_W-1:0]  b,
	output logic [srg_pkg::VAL_W-1:0]  y
);

	logic [31:0] a_x;
	logic [31:0] b_x;
	logic [31:0] sum;

	// a - b, wrapped by one modulus when it would go negative
	always_comb begin
		a_x = {1'b0, a};
		b_x = {2'b00, b};
		if (a_x >= b_x) begin
			sum = a_x - b_x;
		end else begin
			sum = a_x + {2'b00, srg_pkg::MOD_BIG} - b_x;
		end
		y = sum[srg_pkg::VAL_W-1:0];
	end

endmodule

// File: rtl/srg_table.sv
module srg_table (
	input  logic                      clk,
	input  srg_pkg::ram_ctl_t         ctl,
	output logic [srg_pkg::VAL_W-1:0] rd_a,
	output logic [srg_pkg::VAL_W-1:0] rd_b
);

	logic [srg_pkg::VAL_W-1:0] mem [0:srg_pkg::TAB_LEN-1];

	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem[ctl.waddr] <= ctl.wdata;
		end
		if (ctl.re) begin
			rd_a <= mem[ctl.raddr_a];
			rd_b <= mem[ctl.raddr_b];
		end
	end

endmodule

// File: rtl/subtractive_random_generator.sv
// Subtractive random generator: each request transaction returns one draw in
// 0..999999999 (fraction = value * 1e-9). For a plain draw the accept cycle
// issues both table reads; then, once the result register is free or is
// being read out, the block subtracts, writes back and loads the result
// register. A seed request, and the first request after reset whatever its
// type, goes through the accept cycle, the seed fold, the table fill, the
// four mixing passes (one entry per cycle through the registered read port)
// and the draw start. The fill, mixing and draw arithmetic goes through one
// shared subtract-and-wrap unit and the 55-entry table has a single write
// port. The block takes no new request until its draw is done; a finished
// draw waits in the result register while the next request is accepted.
module subtractive_random_generator (
	input  logic     clk,
	input  logic     arst_n,
	srg_in_if.sink   req,
	srg_out_if.source rsp
);

	localparam logic [srg_pkg::IDX_W-1:0] TAB_LAST = srg_pkg::LAST_ADDR;

	srg_pkg::state_t state_q, state_d;

	logic                        seeded_q;
	logic [srg_pkg::IDX_W-1:0]   lead_q, trail_q;
	logic [srg_pkg::SEED_W-1:0]  seed_q, diff_q;
	logic [srg_pkg::VAL_W-1:0]   prev_q, cur_q;
	logic [srg_pkg::IDX_W-1:0]   faddr_q, cnt_q;
	logic [srg_pkg::IDX_W-1:0]   mix_i_q, mix_o_q;
	logic [1:0]                  pass_q;
	logic                        wr_v_s1;
	logic [srg_pkg::IDX_W-1:0]   wr_addr_s1;
	logic                        rsp_valid_q;
	logic [srg_pkg::VAL_W-1:0]   value_q;

	logic                        accept, need_seed, launch, draw_fire;
	logic [srg_pkg::IDX_W-1:0]   lead_nx, trail_nx;
	logic [srg_pkg::SEED_W-1:0]  alu_a;
	logic [srg_pkg::VAL_W-1:0]   alu_b, alu_y;
	logic [srg_pkg::VAL_W-1:0]   rd_a, rd_b;
	logic [srg_pkg::IDX_W:0]     faddr_sum;
	logic [srg_pkg::IDX_W-1:0]   faddr_nx;
	logic                        mix_last;
	srg_pkg::ram_ctl_t           ram_ctl;

	function automatic logic [srg_pkg::IDX_W-1:0] adv (input logic [srg_pkg::IDX_W-1:0] x);
		logic [srg_pkg::IDX_W-1:0] r;
		if (x >= srg_pkg::IDX_W'(srg_pkg::TAB_LEN)) begin
			r = srg_pkg::IDX_W'(1);
		end else begin
			r = x + srg_pkg::IDX_W'(1);
		end
		return r;
	endfunction

	srg_alu u_alu (
		.a (alu_a),
		.b (alu_b),
		.y (alu_y)
	);

	srg_table u_table (
		.clk  (clk),
		.ctl  (ram_ctl),
		.rd_a (rd_a),
		.rd_b (rd_b)
	);

	assign accept    = req.valid && req.ready;
	assign need_seed = req.req_type || !seeded_q;
	assign lead_nx   = adv(lead_q);
	assign trail_nx  = adv(trail_q);
	assign faddr_sum = {1'b0, faddr_q} + {1'b0, srg_pkg::SCRAMBLE};
	assign faddr_nx  = (faddr_sum >= (srg_pkg::IDX_W+1)'(srg_pkg::TAB_LEN)) ?
		srg_pkg::IDX_W'(faddr_sum - (srg_pkg::IDX_W+1)'(srg_pkg::TAB_LEN)) :
		faddr_sum[srg_pkg::IDX_W-1:0];
	assign mix_last  = (pass_q == 2'd3) && (mix_i_q == TAB_LAST);

	assign rsp.valid = rsp_valid_q;
	assign rsp.value = value_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			srg_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = need_seed ? srg_pkg::ST_SEED_ABS : srg_pkg::ST_DRAW;
				end
			end
			srg_pkg::ST_SEED_ABS: state_d = srg_pkg::ST_SEED_MOD;
			srg_pkg::ST_SEED_MOD: state_d = srg_pkg::ST_FILL;
			srg_pkg::ST_FILL: begin
				if (cnt_q == TAB_LAST) begin
					state_d = srg_pkg::ST_MIX;
				end
			end
			srg_pkg::ST_MIX: begin
				if (mix_last) begin
					state_d = srg_pkg::ST_MIX_END;
				end
			end
			srg_pkg::ST_MIX_END: state_d = srg_pkg::ST_PREP;
			srg_pkg::ST_PREP:    state_d = srg_pkg::ST_DRAW;
			srg_pkg::ST_DRAW: begin
				if (draw_fire) begin
					state_d = srg_pkg::ST_IDLE;
				end
			end
			default: state_d = srg_pkg::ST_IDLE;
		endcase
	end

	// outputs: handshake, table port, shared unit operands
	always_comb begin
		req.ready = 1'b0;
		launch    = 1'b0;
		draw_fire = 1'b0;
		alu_a     = {1'b0, rd_a};
		alu_b     = rd_b;
		ram_ctl   = '0;
		unique case (state_q)
			srg_pkg::ST_IDLE: begin
				req.ready = 1'b1;
				launch    = accept && !need_seed;
			end
			srg_pkg::ST_SEED_MOD: begin
				alu_a         = diff_q;
				alu_b         = srg_pkg::MOD_BIG;
				ram_ctl.we    = 1'b1;
				ram_ctl.waddr = TAB_LAST;
				ram_ctl.wdata = alu_y;
			end
			srg_pkg::ST_FILL: begin
				alu_a         = {1'b0, prev_q};
				alu_b         = cur_q;
				ram_ctl.we    = 1'b1;
				ram_ctl.waddr = faddr_q;
				ram_ctl.wdata = cur_q;
			end
			srg_pkg::ST_MIX: begin
				ram_ctl.re      = 1'b1;
				ram_ctl.raddr_a = mix_i_q;
				ram_ctl.raddr_b = mix_o_q;
			end
			srg_pkg::ST_PREP: begin
				launch = 1'b1;
			end
			srg_pkg::ST_DRAW: begin
				draw_fire = !rsp_valid_q || rsp.ready;
			end
			default: begin
			end
		endcase
		if (launch) begin
			ram_ctl.re      = 1'b1;
			ram_ctl.raddr_a = lead_nx - srg_pkg::IDX_W'(1);
			ram_ctl.raddr_b = trail_nx - srg_pkg::IDX_W'(1);
		end
		// mixing write-back comes in the cycle after its read
		if (wr_v_s1) begin
			ram_ctl.we    = 1'b1;
			ram_ctl.waddr = wr_addr_s1;
			ram_ctl.wdata = alu_y;
		end
		if (draw_fire) begin
			ram_ctl.we    = 1'b1;
			ram_ctl.waddr = lead_q - srg_pkg::IDX_W'(1);
			ram_ctl.wdata = alu_y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= srg_pkg::ST_IDLE;
			seeded_q    <= 1'b0;
			lead_q      <= '0;
			trail_q     <= '0;
			cnt_q       <= '0;
			faddr_q     <= '0;
			mix_i_q     <= '0;
			mix_o_q     <= '0;
			pass_q      <= '0;
			wr_v_s1     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			wr_v_s1 <= (state_q == srg_pkg::ST_MIX);
			if (state_q == srg_pkg::ST_SEED_MOD) begin
				cnt_q   <= srg_pkg::IDX_W'(1);
				faddr_q <= srg_pkg::SCRAMBLE - srg_pkg::IDX_W'(1);
				mix_i_q <= '0;
				mix_o_q <= srg_pkg::MIX_OFFSET + srg_pkg::IDX_W'(1);
				pass_q  <= '0;
			end
			if (state_q == srg_pkg::ST_FILL) begin
				cnt_q   <= cnt_q + srg_pkg::IDX_W'(1);
				faddr_q <= faddr_nx;
			end
			if (state_q == srg_pkg::ST_MIX) begin
				if (mix_i_q == TAB_LAST) begin
					mix_i_q <= '0;
					pass_q  <= pass_q + 2'd1;
				end else begin
					mix_i_q <= mix_i_q + srg_pkg::IDX_W'(1);
				end
				mix_o_q <= (mix_o_q == TAB_LAST) ? '0 : mix_o_q + srg_pkg::IDX_W'(1);
			end
			if (state_q == srg_pkg::ST_MIX_END) begin
				lead_q   <= '0;
				trail_q  <= srg_pkg::TRAIL_START;
				seeded_q <= 1'b1;
			end
			if (launch) begin
				lead_q  <= lead_nx;
				trail_q <= trail_nx;
			end
			if (draw_fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			seed_q <= req.seed;
		end
		if (state_q == srg_pkg::ST_SEED_ABS) begin
			diff_q <= (seed_q >= srg_pkg::SEED_MIX) ? seed_q - srg_pkg::SEED_MIX :
				srg_pkg::SEED_MIX - seed_q;
		end
		if (state_q == srg_pkg::ST_SEED_MOD) begin
			prev_q <= alu_y;
			cur_q  <= srg_pkg::VAL_W'(1);
		end
		if (state_q == srg_pkg::ST_FILL) begin
			prev_q <= cur_q;
			cur_q  <= alu_y;
		end
		if (state_q == srg_pkg::ST_MIX) begin
			wr_addr_s1 <= mix_i_q;
		end
		if (draw_fire) begin
			value_q <= alu_y;
		end
	end

`ifndef SYNTHESIS
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != srg_pkg::ST_IDLE))
		else $error("request accepted but sequencer stayed idle");

	a_mix_write_in_mix: assert property (@(posedge clk) disable iff (!arst_n)
		wr_v_s1 |-> (state_q == srg_pkg::ST_MIX || state_q == srg_pkg::ST_MIX_END))
		else $error("mixing write-back outside mixing");

	a_draw_seeded: assert property (@(posedge clk) disable iff (!arst_n)
		draw_fire |-> (seeded_q && lead_q >= 6'd1 && lead_q <= 6'd55
			&& trail_q >= 6'd1 && trail_q <= 6'd55))
		else $error("draw from unseeded table or index out of range");

	a_value_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> (value_q < srg_pkg::MOD_BIG))
		else $error("draw not below modulus");

	a_fill_ends_at_mix: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == srg_pkg::ST_FILL && cnt_q == TAB_LAST) |=>
			(state_q == srg_pkg::ST_MIX && pass_q == 2'd0 && mix_i_q == 6'd0))
		else $error("fill did not hand over to mixing");
`endif

endmodule
